FILE: src/qtr_pkg.sv
`default_nettype none

package qtr_pkg;

    localparam int MAX_TOKEN = 32;
    localparam int LEN_W     = 5;
    localparam int CAP_W     = 6;
    localparam int CONS_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int KIND_W    = 3;

    localparam logic [LEN_W-1:0]  MAX_KEEP = LEN_W'(MAX_TOKEN - 1);
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(32);
    localparam logic [CONS_W-1:0] CONS_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_CHAR     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAIN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUOTED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNCLOSED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STRAY    = 3'd5;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_HT     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'd34;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'd39;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'd41;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'd44;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'd59;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_QUOTED,
        ST_PLAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_STATUS
    } qtr_state_t;

    typedef struct packed {
        logic              clear;
        logic              consume;
        logic              keep;
        logic              set_quote;
        logic              finish;
        logic [KIND_W-1:0] kind;
        logic              rd;
        logic              load_char;
        logic              load_status;
    } qtr_cmd_t;

    typedef struct packed {
        logic is_zero;
        logic is_space;
        logic is_quote;
        logic is_delim;
        logic close_match;
        logic len_zero;
        logic idx_last;
        logic out_free;
    } qtr_stat_t;

endpackage

`default_nettype wire

FILE: src/quoted_token_reader.sv
// After the terminating word is taken, each character is read from the token store in ST_EMIT_RD
// and loaded into the output register in ST_EMIT_LD; the status word is loaded in ST_STATUS once the output is free.
// Throughput: input words are taken one per cycle while a token is read; the buffered token
// then leaves one character word at a time through the store read port, followed by the status word.
// Reset (rst_n low, asynchronous) returns to waiting for a token start and sets capacity to 32;
// the token store is not cleared.
`default_nettype none

module quoted_token_reader
    import qtr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,   // token_capacity
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,     // char_code
    input  wire logic              s_tuser,     // start_token
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,     // out_char, token_length, chars_consumed
    output logic [KIND_W-1:0]      m_tuser,     // result_kind
    output logic                   m_tlast      // run_last
);

    qtr_cmd_t  cmd;
    qtr_stat_t stat;

    qtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    qtr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: src/qtr_ctrl.sv
`default_nettype none

module qtr_ctrl
    import qtr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    input  wire logic      s_tuser,
    input  wire qtr_stat_t stat,
    output logic           in_ready,
    output qtr_cmd_t       cmd
);

    qtr_state_t state_reg;
    qtr_state_t state_next;
    qtr_state_t mode;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE) || (state_reg == ST_SKIP) ||
                     (state_reg == ST_QUOTED) || (state_reg == ST_PLAIN);
        accept     = s_tvalid && in_ready;
        mode       = (accept && s_tuser) ? ST_SKIP : state_reg;
        cmd.clear  = accept && s_tuser;

        if (accept)
        begin
            case (mode)
                ST_SKIP:
                begin
                    state_next = ST_SKIP;
                    if (stat.is_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_NONE;
                    end
                    else if (stat.is_space)
                    begin
                        cmd.consume = 1'b1;
                    end
                    else if (stat.is_quote)
                    begin
                        cmd.set_quote = 1'b1;
                        cmd.consume   = 1'b1;
                        state_next    = ST_QUOTED;
                    end
                    else if (stat.is_delim)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_PLAIN;
                    end
                    else
                    begin
                        cmd.keep    = 1'b1;
                        cmd.consume = 1'b1;
                        state_next  = ST_PLAIN;
                    end
                end
                ST_QUOTED:
                begin
                    if (stat.is_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_UNCLOSED;
                    end
                    else if (stat.close_match)
                    begin
                        cmd.consume = 1'b1;
                        cmd.finish  = 1'b1;
                        cmd.kind    = KIND_QUOTED;
                    end
                    else
                    begin
                        cmd.keep    = 1'b1;
                        cmd.consume = 1'b1;
                    end
                end
                ST_PLAIN:
                begin
                    if (stat.is_zero || stat.is_delim)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_PLAIN;
                    end
                    else if (stat.is_quote)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_STRAY;
                    end
                    else
                    begin
                        cmd.keep    = 1'b1;
                        cmd.consume = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.finish)
            begin
                state_next = ST_EMIT_RD;
            end
        end
        else
        begin
            case (state_reg)
                ST_EMIT_RD:
                begin
                    if (stat.len_zero)
                    begin
                        state_next = ST_STATUS;
                    end
                    else
                    begin
                        cmd.rd     = 1'b1;
                        state_next = ST_EMIT_LD;
                    end
                end
                ST_EMIT_LD:
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_char = 1'b1;
                        state_next    = stat.idx_last ? ST_STATUS : ST_EMIT_RD;
                    end
                end
                ST_STATUS:
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_status = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/qtr_datapath.sv
`default_nettype none

module qtr_datapath
    import qtr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    input  wire qtr_cmd_t          cmd,
    input  wire logic              m_tready,
    output qtr_stat_t              stat,
    output logic                   m_tvalid,
    output logic [31:0]            m_tdata,
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast
);

    logic [CHAR_W-1:0] store_mem [0:MAX_TOKEN-2];
    logic [CHAR_W-1:0] rd_data_reg;

    logic [CAP_W-1:0]  cap_reg;
    logic              qd_reg, qd_next;
    logic [LEN_W-1:0]  kept_reg, kept_next;
    logic [LEN_W-1:0]  trim_reg, trim_next;
    logic [CONS_W-1:0] cons_reg, cons_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              mv_reg, mv_next;
    logic [CHAR_W-1:0] mc_reg, mc_next;
    logic [KIND_W-1:0] mk_reg, mk_next;
    logic              ml_reg, ml_next;
    logic [LEN_W-1:0]  mlen_reg, mlen_next;
    logic [CONS_W-1:0] mcons_reg, mcons_next;

    logic [LEN_W-1:0]  kept_base, trim_base;
    logic [CONS_W-1:0] cons_base;
    logic [CAP_W-1:0]  cap_m1;
    logic [LEN_W-1:0]  keep_limit;
    logic              do_write;

    always_comb
    begin
        stat.is_zero  = (char_code == CH_NUL);
        stat.is_space = ((char_code >= CH_HT) && (char_code <= CH_CR)) ||
                        (char_code == CH_SPACE);
        stat.is_quote = (char_code == CH_DQUOTE) || (char_code == CH_SQUOTE);
        stat.is_delim = (char_code == CH_COMMA) || (char_code == CH_RPAREN) ||
                        (char_code == CH_SEMI) || (char_code == CH_SPACE);
        stat.close_match = qd_reg ? (char_code == CH_DQUOTE) : (char_code == CH_SQUOTE);
        stat.len_zero = (len_reg == '0);
        stat.idx_last = (LEN_W'(idx_reg + 1'b1) == len_reg);
        stat.out_free = !mv_reg || m_tready;
    end

    always_comb
    begin
        cap_m1 = cap_reg - 1'b1;
        if (cap_reg == '0)
        begin
            keep_limit = '0;
        end
        else if (cap_m1 > CAP_W'(MAX_KEEP))
        begin
            keep_limit = MAX_KEEP;
        end
        else
        begin
            keep_limit = cap_m1[LEN_W-1:0];
        end
    end

    always_comb
    begin
        kept_base = cmd.clear ? '0 : kept_reg;
        trim_base = cmd.clear ? '0 : trim_reg;
        cons_base = cmd.clear ? '0 : cons_reg;
        qd_next   = cmd.clear ? 1'b0 : qd_reg;
        kept_next = kept_base;
        trim_next = trim_base;
        cons_next = cons_base;
        len_next  = len_reg;
        kind_next = kind_reg;
        idx_next  = idx_reg;
        do_write  = cmd.keep && (kept_base < keep_limit);

        if (do_write)
        begin
            kept_next = LEN_W'(kept_base + 1'b1);
            if (!stat.is_space)
            begin
                trim_next = LEN_W'(kept_base + 1'b1);
            end
        end
        if (cmd.consume && (cons_base != CONS_MAX))
        begin
            cons_next = CONS_W'(cons_base + 1'b1);
        end
        if (cmd.set_quote)
        begin
            qd_next = (char_code == CH_DQUOTE);
        end
        if (cmd.finish)
        begin
            kind_next = cmd.kind;
            idx_next  = '0;
            if (cmd.kind == KIND_PLAIN)
            begin
                len_next = trim_base;
            end
            else if (cmd.kind == KIND_QUOTED)
            begin
                len_next = kept_base;
            end
            else
            begin
                len_next = '0;
            end
        end
        if (cmd.load_char)
        begin
            idx_next = LEN_W'(idx_reg + 1'b1);
        end
    end

    always_comb
    begin
        mv_next    = mv_reg && !m_tready;
        mc_next    = mc_reg;
        mk_next    = mk_reg;
        ml_next    = ml_reg;
        mlen_next  = mlen_reg;
        mcons_next = mcons_reg;
        if (cmd.load_char)
        begin
            mv_next    = 1'b1;
            mc_next    = rd_data_reg;
            mk_next    = KIND_CHAR;
            ml_next    = 1'b0;
            mlen_next  = '0;
            mcons_next = '0;
        end
        else if (cmd.load_status)
        begin
            mv_next    = 1'b1;
            mc_next    = CH_NUL;
            mk_next    = kind_reg;
            ml_next    = 1'b1;
            mlen_next  = len_reg;
            mcons_next = cons_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[kept_base] <= char_code;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            qd_reg    <= 1'b0;
            kept_reg  <= '0;
            trim_reg  <= '0;
            cons_reg  <= '0;
            len_reg   <= '0;
            kind_reg  <= KIND_CHAR;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            qd_reg   <= qd_next;
            kept_reg <= kept_next;
            trim_reg <= trim_next;
            cons_reg <= cons_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
            idx_reg  <= idx_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg    <= mc_next;
        mk_reg    <= mk_next;
        ml_reg    <= ml_next;
        mlen_reg  <= mlen_next;
        mcons_reg <= mcons_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, mcons_reg, mlen_reg, mc_reg};
    assign m_tuser  = mk_reg;
    assign m_tlast  = ml_reg;

`ifndef SYNTH
    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_char && cmd.load_status))
        else $error("character and status loaded together");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !m_tready) |-> !(cmd.load_char || cmd.load_status))
        else $error("stalled output word overwritten");
    a_trim_within_kept: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= kept_reg)
        else $error("trimmed length exceeds kept count");
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd || cmd.load_char) |-> (idx_reg < len_reg))
        else $error("emit index past token length");
`endif

endmodule

`default_nettype wire

FILE: verif/token_stream_checker.sv
`timescale 1ns / 1ps

module token_stream_checker
    import qtr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [31:0]       m_tdata,
    input  wire logic [KIND_W-1:0] m_tuser,
    input  wire logic              m_tlast,
    output int                     fail_count,
    output int                     words_due
);

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_SKIP,
        RD_QUOTED,
        RD_PLAIN
    } read_phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [CONS_W-1:0] cons;
    } token_word_t;

    read_phase_t       phase = RD_IDLE;
    logic              quote_dbl = 1'b0;
    int                kept = 0;
    logic [CONS_W-1:0] consumed = '0;
    logic [CAP_W-1:0]  capacity = CAP_RESET;
    logic [CHAR_W-1:0] token_copy [MAX_TOKEN-1];
    token_word_t       token_words_due [$];
    int                mismatches = 0;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c >= CH_HT && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic logic is_quote(input logic [CHAR_W-1:0] c);
        return c == CH_DQUOTE || c == CH_SQUOTE;
    endfunction

    function automatic int keep_limit(input logic [CAP_W-1:0] cap);
        if (cap == '0)
            return 0;
        if (int'(cap) - 1 > MAX_TOKEN - 1)
            return MAX_TOKEN - 1;
        return int'(cap) - 1;
    endfunction

    task automatic push_word(input logic [CHAR_W-1:0] ch, input logic [KIND_W-1:0] kind,
                             input logic last, input int len);
        token_word_t w;
        w.ch   = ch;
        w.kind = kind;
        w.last = last;
        w.len  = LEN_W'(len);
        w.cons = last ? consumed : '0;
        token_words_due.push_back(w);
    endtask

    task automatic count_consumed();
        if (consumed != CONS_MAX)
            consumed = consumed + 1'b1;
    endtask

    task automatic keep_char(input logic [CHAR_W-1:0] c);
        if (kept < keep_limit(capacity))
        begin
            token_copy[kept] = c;
            kept++;
        end
    endtask

    task automatic finish_token(input logic [KIND_W-1:0] kind, input int len);
        int i;
        for (i = 0; i < len; i++)
            push_word(token_copy[i], KIND_CHAR, 1'b0, 0);
        push_word(CH_NUL, kind, 1'b1, len);
        phase = RD_IDLE;
    endtask

    task automatic finish_error(input logic [KIND_W-1:0] kind);
        push_word(CH_NUL, kind, 1'b1, 0);
        phase = RD_IDLE;
    endtask

    task automatic plain_step(input logic [CHAR_W-1:0] c);
        int t;
        if (c == CH_NUL || c == CH_COMMA || c == CH_RPAREN || c == CH_SEMI || c == CH_SPACE)
        begin
            // Trailing whitespace is dropped from the kept characters.
            t = kept;
            while (t > 0 && is_blank(token_copy[t-1]))
                t--;
            finish_token(KIND_PLAIN, t);
        end
        else if (is_quote(c))
        begin
            finish_error(KIND_STRAY);
        end
        else
        begin
            keep_char(c);
            count_consumed();
        end
    endtask

    task automatic read_char(input logic [CHAR_W-1:0] c, input logic start);
        if (start)
        begin
            phase     = RD_SKIP;
            quote_dbl = 1'b0;
            kept      = 0;
            consumed  = '0;
        end
        case (phase)
            RD_SKIP:
            begin
                if (c == CH_NUL)
                begin
                    finish_error(KIND_NONE);
                end
                else if (is_blank(c))
                begin
                    count_consumed();
                end
                else if (is_quote(c))
                begin
                    quote_dbl = (c == CH_DQUOTE);
                    count_consumed();
                    phase = RD_QUOTED;
                end
                else
                begin
                    phase = RD_PLAIN;
                    plain_step(c);
                end
            end
            RD_QUOTED:
            begin
                if (c == CH_NUL)
                begin
                    finish_error(KIND_UNCLOSED);
                end
                else if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE))
                begin
                    count_consumed();
                    finish_token(KIND_QUOTED, kept);
                end
                else
                begin
                    keep_char(c);
                    count_consumed();
                end
            end
            RD_PLAIN:
            begin
                plain_step(c);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_word();
        token_word_t got;
        token_word_t want;
        got.ch   = m_tdata[CHAR_W-1:0];
        got.len  = m_tdata[CHAR_W +: LEN_W];
        got.cons = m_tdata[CHAR_W+LEN_W +: CONS_W];
        got.kind = m_tuser;
        got.last = m_tlast;
        if (token_words_due.size() == 0)
        begin
            if (mismatches < 10)
                $display("token_stream_checker: unexpected word char %0d kind %0d last %0d len %0d consumed %0d",
                         got.ch, got.kind, got.last, got.len, got.cons);
            mismatches++;
        end
        else
        begin
            want = token_words_due.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("token_stream_checker: expected char %0d kind %0d last %0d len %0d consumed %0d, got char %0d kind %0d last %0d len %0d consumed %0d",
                             want.ch, want.kind, want.last, want.len, want.cons,
                             got.ch, got.kind, got.last, got.len, got.cons);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = RD_IDLE;
            quote_dbl = 1'b0;
            kept      = 0;
            consumed  = '0;
            capacity  = CAP_RESET;
            token_words_due.delete();
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_tvalid && s_tready)
                read_char(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_word();
        end
        fail_count <= mismatches;
        words_due  <= token_words_due.size();
    end

endmodule

FILE: verif/quoted_token_reader_tb.sv
`timescale 1ns / 1ps

module quoted_token_reader_tb;
    import qtr_pkg::*;

    localparam int RUN_LIMIT    = 200_000;
    localparam int RANDOM_ITEMS = 440;
    localparam int PHASE_ITEMS  = 40;
    localparam int LONG_HOLD    = 600;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;

    int fail_count;
    int words_due;
    int cycle_count = 0;
    int items_sent = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_req = 1'b0;
    bit token_head = 1'b0;

    quoted_token_reader u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    token_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("quoted_token_reader_tb: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        if (r == 5)
            return CH_SPACE;
        return CH_HT + 8'(r);
    endfunction

    function automatic logic [7:0] pick_plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_RPAREN || c == CH_SEMI || c == CH_SPACE ||
               c == CH_DQUOTE || c == CH_SQUOTE || (c >= CH_HT && c <= CH_CR))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 4))
            0: return CH_NUL;
            1: return CH_COMMA;
            2: return CH_RPAREN;
            3: return CH_SEMI;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic send_word(input logic [7:0] c, input logic start);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        gap = tx_calm ? 0 : pick_gap(30);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        send_word(c, token_head);
        token_head = 1'b0;
    endtask

    task automatic send_run(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_word(text[i], i == 0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_token();
        int shape;
        int lead;
        int len;
        int i;
        int r;
        bit stray;
        logic [7:0] q;
        logic [7:0] c;
        shape = $urandom_range(0, 99);
        token_head = 1'b1;
        stray = 1'b0;
        if (shape < 10)
        begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        else
        begin
            lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < lead; i++)
                send_char(pick_blank());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (shape < 50)
            begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                send_char(q);
                for (i = 0; i < len; i++)
                begin
                    c = 8'($urandom_range(1, 255));
                    if (c == q)
                        c = CH_COMMA;
                    send_char(c);
                end
                // Most quotes close; some hit the end of text, a few are left open.
                r = $urandom_range(0, 19);
                if (r < 17)
                    send_char(q);
                else if (r < 19)
                    send_char(CH_NUL);
            end
            else
            begin
                send_char(pick_plain_char());
                for (i = 0; i < len && !stray; i++)
                begin
                    r = $urandom_range(0, 39);
                    if (r < 6)
                    begin
                        send_char(pick_blank() == CH_SPACE ? CH_HT : pick_blank());
                    end
                    else if (r == 6)
                    begin
                        send_char($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                        stray = 1'b1;
                    end
                    else
                    begin
                        send_char(pick_plain_char());
                    end
                end
                if (!stray)
                    send_char(pick_delim());
            end
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (rx_calm || $urandom_range(0, 99) < 70)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left = pick_gap(100) - 1;
            end
        end
    end

    initial
    begin
        int phase_no;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word("x", 1'b0);
        send_run(" ab,");
        send_run("'\"q'");
        send_run("\t");
        send_word(CH_NUL, 1'b0);
        send_run("\"z");
        send_word(CH_NUL, 1'b0);
        send_run("k\"");
        send_run("m\t");
        send_word(CH_CR, 1'b0);
        send_word(CH_RPAREN, 1'b0);
        send_run("n;");
        send_run("p ");
        send_run("r");
        send_word(CH_NUL, 1'b0);
        send_run("ab");
        send_run("c,");
        send_run("\"\"");
        send_word(8'hff, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(CH_COMMA, 1'b0);
        send_word(CH_NUL, 1'b1);
        drain_results();

        items_sent = 0;
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase_no)
                0: write_capacity(6'd0);
                1: write_capacity(6'd1);
                2: write_capacity(6'd63);
                3: write_capacity(6'd2);
                4: write_capacity(6'd31);
                5: write_capacity(6'd32);
                default: write_capacity(CAP_W'($urandom_range(0, 63)));
            endcase
            tx_calm = (phase_no % 4 == 3);
            rx_calm = tx_calm;
            if (phase_no == 2)
                hold_req = 1'b1;
            while (items_sent < (phase_no + 1) * PHASE_ITEMS && items_sent < RANDOM_ITEMS)
                send_random_token();
            send_word(CH_NUL, 1'b1);
            drain_results();
            phase_no++;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("quoted_token_reader_tb: done, clean");
        else
            $display("quoted_token_reader_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
src/qtr_pkg.sv
src/qtr_ctrl.sv
src/qtr_datapath.sv
src/quoted_token_reader.sv
verif/token_stream_checker.sv
verif/quoted_token_reader_tb.sv
